// ----- design/sle_pkg.sv -----
// sle_pkg: shared constants for the sequential list engine.
// Field widths, operation and status codes, parameter defaults.
// No dependencies.
package sle_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int ACTION_W = 3;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 7;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_GET    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_LOCATE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

endpackage

// ----- design/sle_ram.sv -----
// sle_ram: generic single-port-write, single-port-read RAM.
// Read data registered. No dependencies.
module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/sequential_list_engine.sv -----
// sequential_list_engine: ordered list of words in one RAM with a length count.
// Uses sle_pkg (codes, widths) and sle_ram (element store).
//
// channel | direction | handshake            | fields
// in      | to block  | in_valid / in_stall  | action, position, value
// out     | from block| out_valid / out_stall| status, data, found_position,
//         |           |                      | list_length, is_empty
//
// Insert shifts the entries from the end down to the position (no shift when
// appending), delete moves the entries behind the position one place toward the
// front, get reads one entry and locate scans from the front until a hit; clear,
// undefined actions, rejected items and locate on an empty list go straight to
// the final state. The RAM port reads one entry and moves one per cycle.
// Reset clears the count and control only; the RAM is not cleared.
// in_stall is high while an item is in work; a held result only stalls the
// item behind it at its final cycle.
module sequential_list_engine #(
	parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sle_pkg::ACTION_W-1:0]      action,
	input  logic [sle_pkg::POS_W-1:0]         position,
	input  logic signed [sle_pkg::VALUE_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sle_pkg::STATUS_W-1:0]      status,
	output logic signed [sle_pkg::VALUE_W-1:0] data,
	output logic [sle_pkg::LEN_W-1:0]         found_position,
	output logic [sle_pkg::LEN_W-1:0]         list_length,
	output logic                              is_empty
);

	localparam int AW    = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW0   = sle_pkg::POS_W > CNT_W ? sle_pkg::POS_W : CNT_W;
	localparam int CW    = (CW0 > AW + 1 ? CW0 : AW + 1) + 1;
	localparam int XW    = DATA_WIDTH > sle_pkg::VALUE_W ? DATA_WIDTH : sle_pkg::VALUE_W;
	localparam int VW    = sle_pkg::VALUE_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_INS_WR = 2'd2;
	localparam logic [1:0] S_FIN    = 2'd3;

	logic [1:0]                   state_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [sle_pkg::ACTION_W-1:0] op_q;
	logic [DATA_WIDTH-1:0]        word_q;
	logic [sle_pkg::STATUS_W-1:0] status_q;
	logic [VW-1:0]                data_q;
	logic [sle_pkg::LEN_W-1:0]    found_q;
	logic                         hit_q;
	logic                         issue_q;
	logic                         first_q;
	logic [AW-1:0]                rd_addr_q;
	logic [AW-1:0]                last_q;
	logic [AW-1:0]                ins_addr_q;
	logic                         vld_s1;
	logic                         first_s1;
	logic [AW-1:0]                addr_s1;

	logic [sle_pkg::STATUS_W-1:0] out_status_q;
	logic [VW-1:0]                out_data_q;
	logic [sle_pkg::LEN_W-1:0]    out_found_q;
	logic [sle_pkg::LEN_W-1:0]    out_len_q;
	logic                         out_empty_q;
	logic                         out_valid_q;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic                  re;
	logic [DATA_WIDTH-1:0] rdata;

	logic [XW-1:0]         val_ext;
	logic [XW-1:0]         rd_ext;
	logic [DATA_WIDTH-1:0] word_in;
	logic [VW-1:0]         rd32;
	logic [CW-1:0]         pos_ext;
	logic [CW-1:0]         cnt_ext;
	logic [CW-1:0]         pos_m1;
	logic [CW-1:0]         cnt_m1;
	logic [CW-1:0]         found_ext;
	logic                  pos_ok_ins;
	logic                  pos_ok_rd;
	logic                  full;
	logic                  accept;
	logic                  res_free;
	logic                  hit_now;
	logic                  at_last;
	logic [CNT_W-1:0]      cnt_nxt;

	sle_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	assign val_ext   = XW'($unsigned(value));
	assign word_in   = val_ext[DATA_WIDTH-1:0];
	assign rd_ext    = XW'(rdata);
	assign rd32      = rd_ext[VW-1:0];
	assign pos_ext   = CW'(position);
	assign cnt_ext   = CW'(cnt_q);
	assign pos_m1    = pos_ext - CW'(1);
	assign cnt_m1    = cnt_ext - CW'(1);
	assign found_ext = CW'(addr_s1) + CW'(1);

	assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= cnt_ext + CW'(1));
	assign pos_ok_rd  = (pos_ext != '0) && (pos_ext <= cnt_ext);
	assign full       = cnt_ext == CW'(CAPACITY);

	assign in_stall = state_q != S_IDLE;
	assign accept   = in_valid && !in_stall;
	assign res_free = !out_valid_q || !out_stall;
	assign at_last  = rd_addr_q == last_q;

	assign hit_now = (state_q == S_SCAN) && vld_s1 && (op_q == sle_pkg::ACT_LOCATE)
		&& (rdata == word_q) && !hit_q;
	assign re      = (state_q == S_SCAN) && issue_q && !hit_now;

	always_comb begin
		we    = 1'b0;
		waddr = ins_addr_q;
		wdata = word_q;
		if (state_q == S_INS_WR) begin
			we = 1'b1;
		end else if (state_q == S_SCAN && vld_s1) begin
			if (op_q == sle_pkg::ACT_INSERT) begin
				we    = 1'b1;
				waddr = addr_s1 + AW'(1);
				wdata = rdata;
			end else if (op_q == sle_pkg::ACT_DELETE && !first_s1) begin
				we    = 1'b1;
				waddr = addr_s1 - AW'(1);
				wdata = rdata;
			end
		end
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (op_q == sle_pkg::ACT_CLEAR) begin
			cnt_nxt = '0;
		end else if (status_q == sle_pkg::ST_OK && op_q == sle_pkg::ACT_INSERT) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end else if (status_q == sle_pkg::ST_OK && op_q == sle_pkg::ACT_DELETE) begin
			cnt_nxt = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= re;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= action;
						word_q   <= word_in;
						status_q <= sle_pkg::ST_OK;
						data_q   <= '0;
						found_q  <= '0;
						hit_q    <= 1'b0;
						first_q  <= 1'b1;
						ins_addr_q <= pos_m1[AW-1:0];
						state_q  <= S_FIN;
						unique case (action)
							sle_pkg::ACT_INSERT: begin
								if (!pos_ok_ins) begin
									status_q <= sle_pkg::ST_BAD_POS;
								end else if (full) begin
									status_q <= sle_pkg::ST_FULL;
								end else if (pos_ext <= cnt_ext) begin
									rd_addr_q <= cnt_m1[AW-1:0];
									last_q    <= pos_m1[AW-1:0];
									issue_q   <= 1'b1;
									state_q   <= S_SCAN;
								end else begin
									state_q <= S_INS_WR;
								end
							end
							sle_pkg::ACT_DELETE: begin
								if (!pos_ok_rd) begin
									status_q <= sle_pkg::ST_BAD_POS;
								end else begin
									rd_addr_q <= pos_m1[AW-1:0];
									last_q    <= cnt_m1[AW-1:0];
									issue_q   <= 1'b1;
									state_q   <= S_SCAN;
								end
							end
							sle_pkg::ACT_GET: begin
								if (!pos_ok_rd) begin
									status_q <= sle_pkg::ST_BAD_POS;
								end else begin
									rd_addr_q <= pos_m1[AW-1:0];
									last_q    <= pos_m1[AW-1:0];
									issue_q   <= 1'b1;
									state_q   <= S_SCAN;
								end
							end
							sle_pkg::ACT_LOCATE: begin
								if (cnt_q != '0) begin
									rd_addr_q <= '0;
									last_q    <= cnt_m1[AW-1:0];
									issue_q   <= 1'b1;
									state_q   <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (re) begin
						first_q  <= 1'b0;
						first_s1 <= first_q;
						addr_s1  <= rd_addr_q;
						if (at_last) begin
							issue_q <= 1'b0;
						end else if (op_q == sle_pkg::ACT_INSERT) begin
							rd_addr_q <= rd_addr_q - AW'(1);
						end else begin
							rd_addr_q <= rd_addr_q + AW'(1);
						end
					end else if (hit_now) begin
						issue_q <= 1'b0;
					end
					if (vld_s1) begin
						if (op_q == sle_pkg::ACT_GET
							|| (op_q == sle_pkg::ACT_DELETE && first_s1)) begin
							data_q <= rd32;
						end
						if (hit_now) begin
							hit_q   <= 1'b1;
							found_q <= found_ext[sle_pkg::LEN_W-1:0];
						end
					end
					if (!re && !vld_s1) begin
						state_q <= (op_q == sle_pkg::ACT_INSERT) ? S_INS_WR : S_FIN;
					end
				end
				S_INS_WR: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_free) begin
						cnt_q        <= cnt_nxt;
						out_status_q <= status_q;
						out_data_q   <= data_q;
						out_found_q  <= found_q;
						out_len_q    <= sle_pkg::LEN_W'(CW'(cnt_nxt));
						out_empty_q  <= cnt_nxt == '0;
						out_valid_q  <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign data           = out_data_q;
	assign found_position = out_found_q;
	assign list_length    = out_len_q;
	assign is_empty       = out_empty_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(cnt_q) <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		we && re |-> waddr != rd_addr_q)
		else $error("write and read hit the same entry");

	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("second item taken while one is in work");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_FIN |=> cnt_q == $past(cnt_q))
		else $error("entry count moved outside the final cycle");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for sequential_list_engine.
// Drives list operations from a queue, predicts each result and checks it.
// Depends on sle_pkg and the sequential_list_engine RTL.
module tb_top;

	localparam int CAP = sle_pkg::CAPACITY_DEF;
	localparam logic [sle_pkg::ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
	localparam logic [sle_pkg::ACTION_W-1:0] ACT_UNUSED_LAST  = 3'd7;
	localparam int HOLDOFF_AT     = 300;
	localparam int HOLDOFF_CYCLES = 600;
	localparam int TAIL_CYCLES    = 200;

	typedef struct packed {
		logic [sle_pkg::ACTION_W-1:0]       action;
		logic [sle_pkg::POS_W-1:0]          position;
		logic signed [sle_pkg::VALUE_W-1:0] value;
	} list_op_t;

	typedef struct packed {
		logic [sle_pkg::STATUS_W-1:0]       status;
		logic signed [sle_pkg::VALUE_W-1:0] data;
		logic [sle_pkg::LEN_W-1:0]          found_position;
		logic [sle_pkg::LEN_W-1:0]          list_length;
		logic                               is_empty;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [sle_pkg::ACTION_W-1:0] action = '0;
	logic [sle_pkg::POS_W-1:0] position = '0;
	logic signed [sle_pkg::VALUE_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [sle_pkg::STATUS_W-1:0] status;
	logic signed [sle_pkg::VALUE_W-1:0] data;
	logic [sle_pkg::LEN_W-1:0] found_position;
	logic [sle_pkg::LEN_W-1:0] list_length;
	logic is_empty;

	list_op_t pending_ops[$];
	list_result_t expected_results[$];

	// shadow of the list used to predict results
	logic [sle_pkg::VALUE_W-1:0] shadow_words[CAP];
	int shadow_count = 0;

	int gen_len = 0;
	int send_idle_pct = 14;
	int recv_idle_pct = 56;
	int ops_accepted = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;
	int mismatch_count = 0;
	list_op_t next_op;
	list_result_t want_result;

	sequential_list_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.data(data),
		.found_position(found_position),
		.list_length(list_length),
		.is_empty(is_empty)
	);

	always #10 clk = ~clk;

	function automatic list_result_t apply_list_op(list_op_t op);
		list_result_t r;
		int p;
		int j;
		r = '0;
		r.status = sle_pkg::ST_OK;
		p = int'(op.position);
		case (op.action)
			sle_pkg::ACT_INSERT: begin
				if (p < 1 || p > shadow_count + 1) begin
					r.status = sle_pkg::ST_BAD_POS;
				end else if (shadow_count >= CAP) begin
					r.status = sle_pkg::ST_FULL;
				end else begin
					for (j = shadow_count; j >= p; j--)
						shadow_words[j] = shadow_words[j - 1];
					shadow_words[p - 1] = op.value;
					shadow_count++;
				end
			end
			sle_pkg::ACT_DELETE: begin
				if (p < 1 || p > shadow_count) begin
					r.status = sle_pkg::ST_BAD_POS;
				end else begin
					r.data = shadow_words[p - 1];
					for (j = p - 1; j + 1 < shadow_count; j++)
						shadow_words[j] = shadow_words[j + 1];
					shadow_count--;
				end
			end
			sle_pkg::ACT_GET: begin
				if (p < 1 || p > shadow_count)
					r.status = sle_pkg::ST_BAD_POS;
				else
					r.data = shadow_words[p - 1];
			end
			sle_pkg::ACT_LOCATE: begin
				for (j = shadow_count - 1; j >= 0; j--)
					if (shadow_words[j] == op.value)
						r.found_position = sle_pkg::LEN_W'(j + 1);
			end
			sle_pkg::ACT_CLEAR: begin
				shadow_count = 0;
			end
			default: begin
			end
		endcase
		r.list_length = sle_pkg::LEN_W'(shadow_count);
		r.is_empty = (shadow_count == 0);
		return r;
	endfunction

	task automatic add_op(logic [sle_pkg::ACTION_W-1:0] act, int pos,
		logic [sle_pkg::VALUE_W-1:0] val);
		list_op_t op;
		op.action = act;
		op.position = sle_pkg::POS_W'(pos);
		op.value = val;
		pending_ops.push_back(op);
		case (act)
			sle_pkg::ACT_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAP) gen_len++;
			sle_pkg::ACT_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
			sle_pkg::ACT_CLEAR: gen_len = 0;
			default: ;
		endcase
	endtask

	// small pool so that locate often hits, plus extremes and full-range words
	function automatic logic [sle_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3, 4, 5: return $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_position(int valid_hi);
		if (valid_hi >= 1 && $urandom_range(0, 99) < 90)
			return $urandom_range(1, valid_hi);
		if ($urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(valid_hi + 1, 127);
	endfunction

	task automatic add_random_ops(int n);
		int i;
		int r;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				add_op(sle_pkg::ACT_INSERT, pick_position(gen_len + 1), pick_value());
			else if (r < 65)
				add_op(sle_pkg::ACT_DELETE, pick_position(gen_len), $urandom);
			else if (r < 78)
				add_op(sle_pkg::ACT_GET, pick_position(gen_len), $urandom);
			else if (r < 90)
				add_op(sle_pkg::ACT_LOCATE, $urandom_range(0, 127), pick_value());
			else if (r < 93)
				add_op(sle_pkg::ACT_CLEAR, $urandom_range(0, 127), $urandom);
			else if (r < 96)
				add_op(sle_pkg::ACTION_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)),
					$urandom_range(0, 127), $urandom);
			else
				add_op(sle_pkg::ACTION_W'($urandom_range(0, 7)), $urandom_range(0, 127),
					$urandom);
		end
	endtask

	task automatic check_field(string name, logic [sle_pkg::VALUE_W-1:0] want,
		logic [sle_pkg::VALUE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// driver: predicts at each accepted transfer, then offers the next op
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= '0;
			position <= '0;
			value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				next_op.action = action;
				next_op.position = position;
				next_op.value = value;
				expected_results.push_back(apply_list_op(next_op));
				ops_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_op = pending_ops.pop_front();
					in_valid <= 1'b1;
					action <= next_op.action;
					position <= next_op.position;
					value <= next_op.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, so the block fills and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else if (!holdoff_done && ops_accepted >= HOLDOFF_AT) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_done <= 1'b1;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end
	end

	// monitor: checks each accepted result transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result transfer: status %0h data %0h", $time,
						status, data);
					mismatch_count++;
				end else begin
					want_result = expected_results.pop_front();
					check_field("status", sle_pkg::VALUE_W'(want_result.status),
						sle_pkg::VALUE_W'(status));
					check_field("data", want_result.data, data);
					check_field("found_position", sle_pkg::VALUE_W'(want_result.found_position),
						sle_pkg::VALUE_W'(found_position));
					check_field("list_length", sle_pkg::VALUE_W'(want_result.list_length),
						sle_pkg::VALUE_W'(list_length));
					check_field("is_empty", sle_pkg::VALUE_W'(want_result.is_empty),
						sle_pkg::VALUE_W'(is_empty));
				end
			end
			out_stall <= (holdoff_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int fill_idx;
		// directed: empty list, bad positions, extremes, locate, undefined actions
		add_op(sle_pkg::ACT_GET, 1, 32'h0);
		add_op(sle_pkg::ACT_DELETE, 1, 32'h0);
		add_op(sle_pkg::ACT_INSERT, 0, 32'h1234_5678);
		add_op(sle_pkg::ACT_INSERT, 2, 32'h1234_5678);
		add_op(sle_pkg::ACT_LOCATE, 0, 32'h0);
		add_op(sle_pkg::ACT_INSERT, 1, 32'h7fff_ffff);
		add_op(sle_pkg::ACT_INSERT, 1, 32'h8000_0000);
		add_op(sle_pkg::ACT_INSERT, 3, 32'hffff_ffff);
		add_op(sle_pkg::ACT_INSERT, 2, 32'h0);
		add_op(sle_pkg::ACT_GET, 1, 32'h0);
		add_op(sle_pkg::ACT_GET, 4, 32'h0);
		add_op(sle_pkg::ACT_GET, 5, 32'h0);
		add_op(sle_pkg::ACT_GET, 127, 32'hffff_ffff);
		add_op(sle_pkg::ACT_LOCATE, 0, 32'h7fff_ffff);
		add_op(sle_pkg::ACT_LOCATE, 0, 32'h0001_2345);
		add_op(sle_pkg::ACT_LOCATE, 127, 32'hffff_ffff);
		add_op(sle_pkg::ACT_DELETE, 2, 32'h0);
		add_op(sle_pkg::ACT_DELETE, 3, 32'h0);
		add_op(sle_pkg::ACT_DELETE, 0, 32'h0);
		add_op(ACT_UNUSED_FIRST, 127, 32'hffff_ffff);
		add_op(sle_pkg::ACTION_W'(ACT_UNUSED_FIRST + 1), 1, 32'h5555_5555);
		add_op(ACT_UNUSED_LAST, 0, 32'haaaa_aaaa);
		add_op(sle_pkg::ACT_CLEAR, 0, 32'h0);
		add_op(sle_pkg::ACT_GET, 1, 32'h0);
		add_op(sle_pkg::ACT_INSERT, 1, 32'h5555_5555);
		// fill to capacity with front inserts, then full, bad position and long walks
		add_op(sle_pkg::ACT_CLEAR, 0, 32'h0);
		for (fill_idx = 0; fill_idx < CAP; fill_idx++)
			add_op(sle_pkg::ACT_INSERT, 1, sle_pkg::VALUE_W'(fill_idx * 7 + 100));
		add_op(sle_pkg::ACT_INSERT, 30, 32'h0bad_0bad);
		add_op(sle_pkg::ACT_INSERT, CAP + 2, 32'h0bad_0bad);
		add_op(sle_pkg::ACT_LOCATE, 0, 32'd100);
		add_op(sle_pkg::ACT_DELETE, 1, 32'h0);
		add_random_ops(380);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0) @(posedge clk);
		@(negedge clk);
		send_idle_pct = 56;
		recv_idle_pct = 14;
		add_random_ops(450);

		while (pending_ops.size() != 0) @(posedge clk);
		@(negedge clk);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_ops(450);

		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/sle_pkg.sv
design/sle_ram.sv
design/sequential_list_engine.sv
tb/tb_top.sv
